>>> sv/tdo_pkg.sv
// Shared types, constants and helpers for the timed digital output block.
package tdo_pkg;

	localparam int TIME_BITS = 32;

	localparam int CMD_W = 4;
	localparam int NOW_W = 32;
	localparam int DLY_W = 31;
	localparam int PLS_W = 31;

	// Stream widths: slave tdata holds now_time, delay_length and pulse_length, byte padded.
	localparam int S_DATA_W = ((NOW_W + DLY_W + PLS_W + 7) / 8) * 8;
	localparam int M_DATA_W = 8;

	typedef logic [TIME_BITS-1:0] time_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 4'd0,
		CMD_SET    = 4'd1,
		CMD_CLEAR  = 4'd2,
		CMD_TOGGLE = 4'd3,
		CMD_PULSE  = 4'd4,
		CMD_DSET   = 4'd5,
		CMD_DCLEAR = 4'd6,
		CMD_DTGL   = 4'd7,
		CMD_DPULSE = 4'd8
	} cmd_t;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_PULSE  = 3'd1,
		MODE_DSET   = 3'd2,
		MODE_DCLR   = 3'd3,
		MODE_DTGL   = 3'd4,
		MODE_DPULSE = 3'd5
	} mode_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [NOW_W-1:0] now_time;
		logic [DLY_W-1:0] delay_length;
		logic [PLS_W-1:0] pulse_length;
	} item_t;

	// Level sits in the lowest bit so the struct packs straight into tdata.
	typedef struct packed {
		logic busy_res;
		logic changed;
		logic level;
	} result_t;

	// A deadline has arrived once (end - now) is zero or negative, which survives wrap.
	function automatic logic deadline_passed(time_t now_t, time_t end_t);
		time_t diff;
		diff = end_t - now_t;
		return (diff == '0) || diff[TIME_BITS-1];
	endfunction

endpackage

>>> sv/tdo_in_stage.sv
// Input register that holds one command beat until the core takes it.
module tdo_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  tdo_pkg::item_t  in_item,
	input  logic            take,
	output logic            valid_s1,
	output tdo_pkg::item_t  item_s1
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

>>> sv/tdo_core.sv
// Pin state, timing mode and deadlines, updated once per command beat; a config write loads the pin level instead.
module tdo_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_level,
	input  logic              step,
	input  tdo_pkg::item_t    item,
	output tdo_pkg::result_t  result
);

	logic            out_level_q;
	tdo_pkg::mode_t  mode_q;
	tdo_pkg::time_t  pulse_end_q;
	tdo_pkg::time_t  delay_end_q;

	logic            level_d;
	tdo_pkg::mode_t  mode_d;
	tdo_pkg::time_t  pulse_end_d;
	tdo_pkg::time_t  delay_end_d;

	tdo_pkg::time_t  now_t;
	tdo_pkg::time_t  dly_t;
	tdo_pkg::time_t  pls_t;
	tdo_pkg::time_t  delay_sum;
	logic            pulse_due;
	logic            delay_due;

	assign now_t     = tdo_pkg::time_t'(item.now_time);
	assign dly_t     = tdo_pkg::time_t'(item.delay_length);
	assign pls_t     = tdo_pkg::time_t'(item.pulse_length);
	assign delay_sum = now_t + dly_t;
	assign pulse_due = tdo_pkg::deadline_passed(now_t, pulse_end_q);
	assign delay_due = tdo_pkg::deadline_passed(now_t, delay_end_q);

	// Next state.
	always_comb begin
		level_d     = out_level_q;
		mode_d      = mode_q;
		pulse_end_d = pulse_end_q;
		delay_end_d = delay_end_q;
		case (tdo_pkg::cmd_t'(item.cmd))
			tdo_pkg::CMD_TICK: begin
				// A tick acts on one deadline at most; a delayed pulse checks its end later.
				case (mode_q)
					tdo_pkg::MODE_PULSE: begin
						if (pulse_due) begin
							level_d = !out_level_q;
							mode_d  = tdo_pkg::MODE_IDLE;
						end
					end
					tdo_pkg::MODE_DSET: begin
						if (delay_due) begin
							level_d = 1'b1;
							mode_d  = tdo_pkg::MODE_IDLE;
						end
					end
					tdo_pkg::MODE_DCLR: begin
						if (delay_due) begin
							level_d = 1'b0;
							mode_d  = tdo_pkg::MODE_IDLE;
						end
					end
					tdo_pkg::MODE_DTGL: begin
						if (delay_due) begin
							level_d = !out_level_q;
							mode_d  = tdo_pkg::MODE_IDLE;
						end
					end
					tdo_pkg::MODE_DPULSE: begin
						if (delay_due) begin
							level_d = !out_level_q;
							mode_d  = tdo_pkg::MODE_PULSE;
						end
					end
					default: begin
					end
				endcase
			end
			tdo_pkg::CMD_SET: begin
				level_d = 1'b1;
				mode_d  = tdo_pkg::MODE_IDLE;
			end
			tdo_pkg::CMD_CLEAR: begin
				level_d = 1'b0;
				mode_d  = tdo_pkg::MODE_IDLE;
			end
			tdo_pkg::CMD_TOGGLE: begin
				level_d = !out_level_q;
				mode_d  = tdo_pkg::MODE_IDLE;
			end
			tdo_pkg::CMD_PULSE: begin
				// A pulse that arrives while busy does not invert the level; it rearms the end time and replaces the pending mode.
				if (mode_q == tdo_pkg::MODE_IDLE) begin
					level_d = !out_level_q;
				end
				pulse_end_d = now_t + pls_t;
				mode_d      = tdo_pkg::MODE_PULSE;
			end
			tdo_pkg::CMD_DSET: begin
				delay_end_d = delay_sum;
				mode_d      = tdo_pkg::MODE_DSET;
			end
			tdo_pkg::CMD_DCLEAR: begin
				delay_end_d = delay_sum;
				mode_d      = tdo_pkg::MODE_DCLR;
			end
			tdo_pkg::CMD_DTGL: begin
				delay_end_d = delay_sum;
				mode_d      = tdo_pkg::MODE_DTGL;
			end
			tdo_pkg::CMD_DPULSE: begin
				delay_end_d = delay_sum;
				pulse_end_d = delay_sum + pls_t;
				mode_d      = tdo_pkg::MODE_DPULSE;
			end
			default: begin
			end
		endcase
	end

	// Outputs.
	always_comb begin
		result.level    = level_d;
		result.changed  = level_d != out_level_q;
		result.busy_res = mode_d != tdo_pkg::MODE_IDLE;
	end

	// The configured initial level is only ever needed at the moment it is written,
	// so it is loaded straight into the pin level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_level_q <= 1'b0;
			mode_q      <= tdo_pkg::MODE_IDLE;
			pulse_end_q <= '0;
			delay_end_q <= '0;
		end else if (cfg_we) begin
			out_level_q <= cfg_level;
		end else if (step) begin
			out_level_q <= level_d;
			mode_q      <= mode_d;
			pulse_end_q <= pulse_end_d;
			delay_end_q <= delay_end_d;
		end
	end

endmodule

>>> sv/tdo_out_stage.sv
// Result register that holds one result beat until the sink takes it.
module tdo_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  tdo_pkg::result_t  result,
	output logic              can_load,
	output logic              out_valid,
	input  logic              out_ready,
	output tdo_pkg::result_t  res_s2
);

	logic valid_s2;

	assign can_load  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (can_load) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= result;
		end
	end

endmodule

>>> sv/timed_digital_output_top.sv
// Top level of the timed digital output block: stream ports, config port and stages.
// Each command beat on s_axis updates the pin state and yields one result beat on
// m_axis. The block takes one beat per clock while m_axis is not stalled. A command
// beat waits in the input register, and its result beat is loaded into the result
// register, which drives m_axis; a stall on m_axis holds both registers. One beat per
// clock holds because the pin, mode and deadline registers take their next state
// straight from each beat, through at most two adds and one signed deadline compare.
// A beat on the cfg port loads the level at once, with no result and no change to
// pending timing; it is meant to be written while no command is in flight. Times wrap
// at 32 bits.
module timed_digital_output_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// From bit 0: now_time[31:0], delay_length[62:32], pulse_length[93:63], zero pad.
	input  logic [tdo_pkg::S_DATA_W-1:0] s_axis_tdata,
	// From bit 0: cmd[3:0].
	input  logic [tdo_pkg::CMD_W-1:0]    s_axis_tuser,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// From bit 0: level, changed, busy_res, zero pad.
	output logic [tdo_pkg::M_DATA_W-1:0] m_axis_tdata,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_data
);

	localparam int DLY_LO = tdo_pkg::NOW_W;
	localparam int PLS_LO = tdo_pkg::NOW_W + tdo_pkg::DLY_W;

	tdo_pkg::item_t    in_item;
	tdo_pkg::item_t    item_s1;
	tdo_pkg::result_t  result;
	tdo_pkg::result_t  res_s2;
	logic              valid_s1;
	logic              can_load;
	logic              step;

	assign in_item.cmd          = s_axis_tuser;
	assign in_item.now_time     = s_axis_tdata[tdo_pkg::NOW_W-1:0];
	assign in_item.delay_length = s_axis_tdata[DLY_LO +: tdo_pkg::DLY_W];
	assign in_item.pulse_length = s_axis_tdata[PLS_LO +: tdo_pkg::PLS_W];

	assign step      = valid_s1 && can_load;
	assign cfg_ready = 1'b1;

	tdo_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.take     (step),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	tdo_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_level (cfg_data),
		.step      (step),
		.item      (item_s1),
		.result    (result)
	);

	tdo_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.result    (result),
		.can_load  (can_load),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res_s2    (res_s2)
	);

	assign m_axis_tdata = {{(tdo_pkg::M_DATA_W - $bits(tdo_pkg::result_t)){1'b0}}, res_s2};

endmodule

>>> sv/tdo_checker.sv
// Port-level checks for the timed digital output block, bound to the top level.
module tdo_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_axis_tvalid,
	input logic                         s_axis_tready,
	input logic                         m_axis_tvalid,
	input logic                         m_axis_tready,
	input logic [tdo_pkg::M_DATA_W-1:0] m_axis_tdata,
	input logic                         cfg_valid,
	input logic                         cfg_ready,
	input logic                         cfg_data
);

	logic       in_beat;
	logic       out_beat;
	logic [2:0] inflight_q;
	logic       last_level_q;

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_beat = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 3'(in_beat) - 3'(out_beat);
		end
	end

	// Level last shown on the pin, from result beats and config writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			last_level_q <= cfg_data;
		end else if (out_beat) begin
			last_level_q <= m_axis_tdata[0];
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat dropped or altered while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> inflight_q != 3'd0)
		else $error("result beat without a command beat in flight");

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd2)
		else $error("more command beats in flight than the two stages hold");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == 3'd0 |-> s_axis_tready)
		else $error("input stalled with nothing in flight");

	a_changed_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> m_axis_tdata[1] == (m_axis_tdata[0] != last_level_q))
		else $error("changed flag disagrees with the level sequence");

endmodule

bind timed_digital_output_top tdo_checker u_tdo_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready),
	.cfg_data      (cfg_data)
);

>>> test/timed_digital_output_checker.sv
// Scoreboard for the timed digital output block: predicts each result beat and compares it.
module timed_digital_output_checker
	import tdo_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	input  logic                s_axis_tready,
	// From bit 0: now_time, delay_length, pulse_length, zero pad.
	input  logic [S_DATA_W-1:0] s_axis_tdata,
	// From bit 0: cmd.
	input  logic [CMD_W-1:0]    s_axis_tuser,
	input  logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// From bit 0: level, changed, busy_res, zero pad.
	input  logic [M_DATA_W-1:0] m_axis_tdata,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic                cfg_data,
	output int                  mismatch_count,
	output int                  results_due
);

	logic    start_level;
	logic    pin;
	mode_t   pin_mode;
	time_t   pulse_deadline;
	time_t   delay_deadline;
	result_t pin_results_due[$];
	int      fails;

	// True once the deadline is at or behind the current time, modulo the counter wrap.
	function automatic logic reached(time_t now_t, time_t end_t);
		time_t left;
		left = end_t - now_t;
		return (left == '0) || ($signed(left) < 0);
	endfunction

	task automatic apply_command(input logic [CMD_W-1:0] op, input time_t now_t,
			input logic [DLY_W-1:0] dly, input logic [PLS_W-1:0] pls);
		logic    next_level;
		result_t r;
		next_level = pin;
		case (op)
			CMD_TICK: begin
				// Only one deadline is acted on per tick.
				case (pin_mode)
					MODE_PULSE: if (reached(now_t, pulse_deadline)) begin
						next_level = ~pin;
						pin_mode = MODE_IDLE;
					end
					MODE_DSET: if (reached(now_t, delay_deadline)) begin
						next_level = 1'b1;
						pin_mode = MODE_IDLE;
					end
					MODE_DCLR: if (reached(now_t, delay_deadline)) begin
						next_level = 1'b0;
						pin_mode = MODE_IDLE;
					end
					MODE_DTGL: if (reached(now_t, delay_deadline)) begin
						next_level = ~pin;
						pin_mode = MODE_IDLE;
					end
					MODE_DPULSE: if (reached(now_t, delay_deadline)) begin
						next_level = ~pin;
						pin_mode = MODE_PULSE;
					end
					default: ;
				endcase
			end
			CMD_SET: begin
				next_level = 1'b1;
				pin_mode = MODE_IDLE;
			end
			CMD_CLEAR: begin
				next_level = 1'b0;
				pin_mode = MODE_IDLE;
			end
			CMD_TOGGLE: begin
				next_level = ~pin;
				pin_mode = MODE_IDLE;
			end
			CMD_PULSE: begin
				// If busy, a pulse keeps the level and sets a new end time and mode.
				if (pin_mode == MODE_IDLE)
					next_level = ~pin;
				pulse_deadline = now_t + pls;
				pin_mode = MODE_PULSE;
			end
			CMD_DSET: begin
				delay_deadline = now_t + dly;
				pin_mode = MODE_DSET;
			end
			CMD_DCLEAR: begin
				delay_deadline = now_t + dly;
				pin_mode = MODE_DCLR;
			end
			CMD_DTGL: begin
				delay_deadline = now_t + dly;
				pin_mode = MODE_DTGL;
			end
			CMD_DPULSE: begin
				delay_deadline = now_t + dly;
				pulse_deadline = now_t + dly + pls;
				pin_mode = MODE_DPULSE;
			end
			default: ;
		endcase
		r.level = next_level;
		r.changed = (next_level != pin);
		r.busy_res = (pin_mode != MODE_IDLE);
		pin = next_level;
		pin_results_due.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t seen;
		result_t want;
		if (!arst_n) begin
			start_level = 1'b0;
			pin = 1'b0;
			pin_mode = MODE_IDLE;
			pulse_deadline = '0;
			delay_deadline = '0;
			pin_results_due.delete();
			fails = 0;
			mismatch_count <= 0;
			results_due <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				start_level = cfg_data;
				pin = start_level;
			end
			if (s_axis_tvalid && s_axis_tready)
				apply_command(s_axis_tuser, s_axis_tdata[NOW_W-1:0],
					s_axis_tdata[NOW_W+DLY_W-1:NOW_W],
					s_axis_tdata[NOW_W+DLY_W+PLS_W-1:NOW_W+DLY_W]);
			if (m_axis_tvalid && m_axis_tready) begin
				seen = result_t'(m_axis_tdata[2:0]);
				if (pin_results_due.size() == 0) begin
					$error("result beat with no command pending: level %0d changed %0d busy %0d",
						seen.level, seen.changed, seen.busy_res);
					fails++;
				end else begin
					want = pin_results_due.pop_front();
					if (seen.level !== want.level) begin
						$error("level: expected %0d, got %0d", want.level, seen.level);
						fails++;
					end
					if (seen.changed !== want.changed) begin
						$error("changed: expected %0d, got %0d", want.changed, seen.changed);
						fails++;
					end
					if (seen.busy_res !== want.busy_res) begin
						$error("busy_res: expected %0d, got %0d", want.busy_res, seen.busy_res);
						fails++;
					end
				end
			end
			mismatch_count <= fails;
			results_due <= pin_results_due.size();
		end
	end

endmodule

>>> test/timed_digital_output_top_tb.sv
// Testbench top for the timed digital output block: stimulus, level writes and verdict.
module timed_digital_output_top_tb;
	import tdo_pkg::*;

	localparam logic [CMD_W-1:0] CMD_RESERVED_LO = 4'd9;
	localparam logic [CMD_W-1:0] CMD_RESERVED_HI = 4'd15;
	localparam logic [DLY_W-1:0] SPAN_MAX = '1;
	localparam int PHASE_ITEMS = 400;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata = '0;
	logic [CMD_W-1:0]    s_axis_tuser = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0] m_axis_tdata;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic                cfg_data = 1'b0;

	int    mismatch_count;
	int    results_due;
	logic  tx_quiet = 1'b0;
	logic  rx_quiet = 1'b0;
	int    rx_wait = 0;
	time_t clock_ms = '0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	timed_digital_output_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	timed_digital_output_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.results_due    (results_due)
	);

	// Result side: after each accepted beat, drop tready for a random wait unless quiet.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if ($urandom_range(0, 47) == 0)
					rx_quiet = ~rx_quiet;
				rx_wait = rx_quiet ? 0 : $urandom_range(0, 15);
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			m_axis_tready <= (rx_wait == 0);
		end
	end

	// Called at a rising edge; returns at the edge where the beat was accepted.
	task automatic send_cmd(input logic [CMD_W-1:0] op, input time_t now_t,
			input logic [DLY_W-1:0] dly, input logic [PLS_W-1:0] pls);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {{(S_DATA_W-NOW_W-DLY_W-PLS_W){1'b0}}, pls, dly, now_t};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic write_start_level(input logic v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
	endtask

	// Mostly short spans so deadlines are hit exactly; now and then a full-range or extreme one.
	function automatic logic [DLY_W-1:0] draw_span();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 85)
			return DLY_W'($urandom_range(0, 12));
		else if (pick < 95)
			return DLY_W'($urandom);
		else if (pick < 97)
			return '0;
		else if (pick < 99)
			return SPAN_MAX;
		else
			return {1'b1, {(DLY_W-1){1'b0}}};
	endfunction

	task automatic send_random_cmd();
		int pick;
		logic [CMD_W-1:0] op;
		if ($urandom_range(0, 63) == 0)
			tx_quiet = ~tx_quiet;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			clock_ms += $urandom_range(0, 4);
		else if (pick < 90)
			clock_ms += $urandom_range(5, 40);
		else if (pick < 95)
			clock_ms = $urandom;
		else
			clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 20);
		pick = $urandom_range(0, 99);
		if (pick < 45)
			op = CMD_TICK;
		else if (pick < 70)
			op = CMD_W'($urandom_range(int'(CMD_SET), int'(CMD_DPULSE)));
		else if (pick < 96)
			op = CMD_W'($urandom_range(int'(CMD_PULSE), int'(CMD_DPULSE)));
		else
			op = CMD_W'($urandom_range(int'(CMD_RESERVED_LO), int'(CMD_RESERVED_HI)));
		send_cmd(op, clock_ms, draw_span(), draw_span());
	endtask

	task automatic run_directed();
		send_cmd(CMD_SET, 32'd100, '0, '0);
		send_cmd(CMD_SET, 32'd100, '0, '0);
		send_cmd(CMD_CLEAR, 32'd101, '0, '0);
		send_cmd(CMD_TOGGLE, 32'd102, '0, '0);
		send_cmd(CMD_PULSE, 32'd200, '0, 31'd10);
		send_cmd(CMD_TICK, 32'd205, '0, '0);
		// Pulse on top of a running pulse: no inversion, end time moves.
		send_cmd(CMD_PULSE, 32'd206, '0, 31'd2);
		send_cmd(CMD_TICK, 32'd208, '0, '0);
		send_cmd(CMD_DCLEAR, 32'd300, 31'd5, '0);
		send_cmd(CMD_TICK, 32'd304, '0, '0);
		send_cmd(CMD_TICK, 32'd305, '0, '0);
		// Deadline wraps past zero.
		send_cmd(CMD_DSET, 32'hFFFF_FFFE, 31'd4, '0);
		send_cmd(CMD_TICK, 32'hFFFF_FFFF, '0, '0);
		send_cmd(CMD_TICK, 32'd2, '0, '0);
		// Longest delay: still pending just before, expired one past the deadline, at half the range.
		send_cmd(CMD_DTGL, 32'd0, SPAN_MAX, '0);
		send_cmd(CMD_TICK, 32'h7FFF_FFFE, '0, '0);
		send_cmd(CMD_TICK, 32'h8000_0000, '0, '0);
		// Delayed pulse: both deadlines are past, but each tick handles only one.
		send_cmd(CMD_DPULSE, 32'd50, 31'd3, 31'd4);
		send_cmd(CMD_TICK, 32'd60, '0, '0);
		send_cmd(CMD_TICK, 32'd60, '0, '0);
		send_cmd(CMD_DTGL, 32'd70, 31'd10, '0);
		send_cmd(CMD_DSET, 32'd71, '0, '0);
		send_cmd(CMD_TICK, 32'd71, '0, '0);
		send_cmd(CMD_RESERVED_HI, 32'hFFFF_FFFF, SPAN_MAX, SPAN_MAX);
		send_cmd(CMD_PULSE, 32'hFFFF_FFFF, '0, SPAN_MAX);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		wait_results_drained();
		for (int ph = 0; ph < 4; ph++) begin
			write_start_level((ph % 2) == 0);
			repeat (PHASE_ITEMS) send_random_cmd();
			wait_results_drained();
		end
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && results_due == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#1000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
